// ===== hdl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants for the sorted two-way merge core
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned LIST_DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_FIRST  = 2'd0,
    MODE_LOAD_SECOND = 2'd1,
    MODE_MERGE       = 2'd2
  } mode_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_e;

  // status of one buffer as seen by the merge sequencer
  typedef struct packed {
    logic                      has_data;  // head below count
    logic                      is_last;   // head is the final held entry
    logic signed [VALUE_W-1:0] head;
  } buf_status_t;

  // commands from the sequencer to one buffer
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } buf_cmd_t;

endpackage

// ===== hdl/swm_buffer.sv =====
// ----------------------------------------------------------------------------
// swm_buffer
// append-only value store with fill count and read head for the merge core
// ----------------------------------------------------------------------------
module swm_buffer #(
  parameter int unsigned Depth = swm_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swm_pkg::buf_cmd_t                 cmd_i,
  input  logic signed [swm_pkg::VALUE_W-1:0] value_i,
  output swm_pkg::buf_status_t              status_o
);
  import swm_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);

  logic signed [VALUE_W-1:0] mem_q [Depth];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] head_q, head_d;
  logic            push_ok;

  // a push to a full buffer is dropped
  assign push_ok = cmd_i.push && (count_q < DepthC);

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    if (cmd_i.clear) begin
      count_d = '0;
      head_d  = '0;
    end else begin
      if (push_ok) count_d = count_q + CntW'(1);
      if (cmd_i.pop) head_d = head_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok && !cmd_i.clear) mem_q[count_q[IdxW-1:0]] <= value_i;
  end

  assign status_o.has_data = (head_q < count_q);
  assign status_o.is_last  = ((head_q + CntW'(1)) == count_q);
  assign status_o.head     = mem_q[head_q[IdxW-1:0]];

endmodule

// ===== hdl/sorted_two_way_merge_core.sv =====
// ----------------------------------------------------------------------------
// sorted_two_way_merge_core
// merges two buffered sorted runs of signed values into one ordered stream
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries mode_i and value_i. Mode
// load-first or load-second appends value_i to that buffer; a push to a
// full buffer is dropped. Mode merge starts a merge run and mode 3 is
// accepted and ignored.
// Output channel (out_valid_o / out_ready_i) carries value_res_o, source_o
// and last_o, one transaction per held value, last_o on the final one.
// In a merge run one shared signed comparator looks at the two buffer heads
// once per cycle while the output register is free and picks one value.
// The merge transaction moves the state register into the merge state; the
// first pick is then loaded into the output register. in_ready_o is low from
// the merge transaction until the final result is loaded into the output
// register; loads are then accepted again while that result still waits.
// A merge of two empty buffers gives no result and returns to idle.
// A receiver stall holds the output register and pauses the merge.
// Reset empties both buffers and clears the output valid flag.
// ----------------------------------------------------------------------------
module sorted_two_way_merge_core #(
  parameter int unsigned LIST_DEPTH = swm_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [swm_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [swm_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [swm_pkg::VALUE_W-1:0] value_res_o,
  output logic                               source_o,
  output logic                               last_o
);
  import swm_pkg::*;

  state_e      state_q, state_d;
  buf_cmd_t    cmd_first, cmd_second;
  buf_status_t st_first, st_second;

  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_source_q, out_last_q;
  logic                      load_out;
  logic                      take_first;
  logic                      pick_last;
  logic                      in_fire;
  logic                      out_free;

  swm_buffer #(.Depth(LIST_DEPTH)) u_first (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_first),
    .value_i  (value_i),
    .status_o (st_first)
  );

  swm_buffer #(.Depth(LIST_DEPTH)) u_second (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_second),
    .value_i  (value_i),
    .status_o (st_second)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // the first buffer wins only on strictly smaller, ties go to the second
  assign take_first = st_first.has_data &&
                      (!st_second.has_data || (st_first.head < st_second.head));
  assign pick_last  = take_first ? (st_first.is_last && !st_second.has_data)
                                 : (st_second.is_last && !st_first.has_data);

  always_comb begin
    state_d    = state_q;
    cmd_first  = '0;
    cmd_second = '0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (mode_e'(mode_i))
            MODE_LOAD_FIRST:  cmd_first.push  = 1'b1;
            MODE_LOAD_SECOND: cmd_second.push = 1'b1;
            MODE_MERGE:       state_d         = ST_MERGE;
            default:          ;
          endcase
        end
      end
      ST_MERGE: begin
        if (!st_first.has_data && !st_second.has_data) begin
          cmd_first.clear  = 1'b1;
          cmd_second.clear = 1'b1;
          state_d          = ST_IDLE;
        end else if (out_free) begin
          load_out       = 1'b1;
          cmd_first.pop  = take_first;
          cmd_second.pop = !take_first;
          if (pick_last) begin
            cmd_first.clear  = 1'b1;
            cmd_second.clear = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q  <= take_first ? st_first.head : st_second.head;
      out_source_q <= !take_first;
      out_last_q   <= pick_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_value_q;
  assign source_o    = out_source_q;
  assign last_o      = out_last_q;

endmodule

// ===== hdl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// port-level checks for the sorted two-way merge core, bound to the top level
// ----------------------------------------------------------------------------
module swm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [swm_pkg::MODE_W-1:0]         mode_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [swm_pkg::VALUE_W-1:0] value_res_o,
  input logic                               source_o,
  input logic                               last_o
);
  import swm_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(value_res_o) && $stable(source_o) && $stable(last_o))
    else $error("stalled result changed");

  // a merge transaction blocks the input
  a_merge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_MERGE) |=> !in_ready_o)
    else $error("input ready right after merge");

  // the input stays blocked while the run is not finished
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready in the middle of a merge run");

  // a run streams without gaps behind an unstalled receiver
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside a merge run");

endmodule

bind sorted_two_way_merge_core swm_checker u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_res_o (value_res_o),
  .source_o    (source_o),
  .last_o      (last_o)
);
